>>> rtl/assert_macros.svh
// Assertion macros for the port checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: post must hold whenever pre holds.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: implication check failed");

// Next-cycle implication: post must hold in the cycle after pre.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/vmie_pkg.sv
// Shared constants and register codes for the 2x2x2 mask erosion block.
// No dependencies; used by the top level and the port checker.
`timescale 1ns / 1ps

package vmie_pkg;

  localparam int MAX_FIRST_AXIS  = 1024;
  localparam int MAX_SECOND_AXIS = 256;
  localparam int MAX_THIRD_AXIS  = 256;

  localparam int POS1_W = $clog2(MAX_FIRST_AXIS);
  localparam int POS2_W = $clog2(MAX_SECOND_AXIS);
  localparam int POS3_W = $clog2(MAX_THIRD_AXIS);

  localparam int SIZE1_W  = 11;
  localparam int SIZE23_W = 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int TDATA_W    = 8;

  localparam int PLANE_DEPTH = MAX_SECOND_AXIS * MAX_THIRD_AXIS;
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_FIRST,
    REG_SIZE_SECOND,
    REG_SIZE_THIRD
  } cfg_reg_t;

endpackage

>>> rtl/vmie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; a read of the address written in the same cycle returns old data.
`timescale 1ns / 1ps

module vmie_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/vmie_cell.sv
// One cell of the row delay chain: loads the new bit when it is the entry
// point, otherwise takes its upstream neighbor's bit. No dependencies.
`timescale 1ns / 1ps

module vmie_cell (
  input  logic clk,
  input  logic shift,
  input  logic inject,
  input  logic din,
  input  logic from_next,
  output logic q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= inject ? din : from_next;
    end
  end

endmodule

>>> rtl/voxel_mask_inset_erosion.sv
// Throughput: one voxel per cycle while the output buffer has room. A result is
// registered into the output buffer in the cycle after the transfer of the voxel that completes its cube.
// Row history: chain of MAX_THIRD_AXIS cells; plane history: one RAM with one
// read and one write per cycle. A two-entry output buffer decouples the sides.
// Reset (rst, synchronous): sizes back to 2, scan position zero, output empty;
// history contents are not cleared and no clearing pass is run.
`timescale 1ns / 1ps

module voxel_mask_inset_erosion (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [vmie_pkg::TDATA_W-1:0]    s_axis_tdata,   // [0] voxel_in_mask
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [vmie_pkg::TDATA_W-1:0]    m_axis_tdata,   // [0] inset_voxel
  output logic                            m_axis_tlast,   // end_of_volume
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vmie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vmie_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int P1 = vmie_pkg::POS1_W;
  localparam int P2 = vmie_pkg::POS2_W;
  localparam int P3 = vmie_pkg::POS3_W;
  localparam int AW = vmie_pkg::PLANE_AW;
  localparam int NCELL = vmie_pkg::MAX_THIRD_AXIS;

  function automatic logic [31:0] clamp_last(input logic [31:0] v, input logic [31:0] max_size);
    logic [31:0] c;
    begin
      c = v;
      if (c < 32'd2) c = 32'd2;
      else if (c > max_size) c = max_size;
      return c - 32'd1;
    end
  endfunction

  // size registers, kept as last index along each axis
  logic [P1-1:0] last1;
  logic [P2-1:0] last2;
  logic [P3-1:0] last3;
  logic [P1-1:0] pos1;
  logic [P2-1:0] pos2;
  logic [P3-1:0] pos3;

  logic cfg_fire, cfg_hit, accept, has_result;
  logic end_k, end_j, end_i;
  logic vin, prev_vin, pair_k, row_tap, pair_j, plane_q, cube;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == vmie_pkg::REG_SIZE_FIRST ||
                                  cfg_index == vmie_pkg::REG_SIZE_SECOND ||
                                  cfg_index == vmie_pkg::REG_SIZE_THIRD);
  assign accept    = s_axis_tvalid & s_axis_tready;

  assign end_k = (pos3 == last3);
  assign end_j = (pos2 == last2);
  assign end_i = (pos1 == last1);
  assign has_result = (pos1 != '0) && (pos2 != '0) && (pos3 != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      last1 <= P1'(1);
      last2 <= P2'(1);
      last3 <= P3'(1);
      pos1  <= '0;
      pos2  <= '0;
      pos3  <= '0;
    end else begin
      if (accept) begin
        if (!end_k) begin
          pos3 <= pos3 + P3'(1);
        end else begin
          pos3 <= '0;
          if (!end_j) begin
            pos2 <= pos2 + P2'(1);
          end else begin
            pos2 <= '0;
            pos1 <= end_i ? '0 : pos1 + P1'(1);
          end
        end
      end
      if (cfg_hit) begin
        pos1 <= '0;
        pos2 <= '0;
        pos3 <= '0;
        case (cfg_index)
          vmie_pkg::REG_SIZE_FIRST: begin
            last1 <= P1'(clamp_last(32'(cfg_data), vmie_pkg::MAX_FIRST_AXIS));
          end
          vmie_pkg::REG_SIZE_SECOND: begin
            last2 <= P2'(clamp_last(32'(cfg_data[vmie_pkg::SIZE23_W-1:0]),
                                    vmie_pkg::MAX_SECOND_AXIS));
          end
          vmie_pkg::REG_SIZE_THIRD: begin
            last3 <= P3'(clamp_last(32'(cfg_data[vmie_pkg::SIZE23_W-1:0]),
                                    vmie_pkg::MAX_THIRD_AXIS));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // pair along the innermost axis
  assign vin = s_axis_tdata[0];
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_vin <= vin;
    end
  end
  assign pair_k = vin & prev_vin;

  // row delay: pair_k enters at cell last3 and reaches cell 0 one row later
  logic row_bit [NCELL];
  for (genvar k = 0; k < NCELL; k++) begin : g_row
    logic upstream;
    if (k == NCELL - 1) begin : g_end
      assign upstream = 1'b0;
    end else begin : g_mid
      assign upstream = row_bit[k+1];
    end
    vmie_cell u_cell (
      .clk       (clk),
      .shift     (accept),
      .inject    (P3'(k) == last3),
      .din       (pair_k),
      .from_next (upstream),
      .q         (row_bit[k])
    );
  end
  assign row_tap = row_bit[0];
  assign pair_j  = pair_k & row_tap;

  // plane delay: circular RAM over one plane length
  logic [P2:0] len2;
  logic [P3:0] len3;
  logic [P2+P3+1:0] plane_len;
  logic [AW-1:0] plane_last, plane_ptr, plane_ptr_next, plane_raddr;

  assign len2 = {1'b0, last2} + (P2+1)'(1);
  assign len3 = {1'b0, last3} + (P3+1)'(1);
  assign plane_len  = len2 * len3;
  assign plane_last = AW'(plane_len - (P2+P3+2)'(1));
  assign plane_ptr_next = (plane_ptr == plane_last) ? '0 : plane_ptr + AW'(1);

  always_comb begin
    if (cfg_hit) plane_raddr = '0;
    else if (accept) plane_raddr = plane_ptr_next;
    else plane_raddr = plane_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      plane_ptr <= '0;
    end else if (accept) begin
      plane_ptr <= plane_ptr_next;
    end
  end

  vmie_ram #(
    .WIDTH (1),
    .DEPTH (vmie_pkg::PLANE_DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (accept),
    .waddr (plane_ptr),
    .wdata (pair_j),
    .raddr (plane_raddr),
    .rdata (plane_q)
  );

  assign cube = pair_j & plane_q;

  // two-entry output buffer, entry = {end_of_volume, inset_voxel}
  logic [1:0] obuf [2];
  logic [1:0] out_cnt;
  logic push, pop, to_second;

  assign push = accept & has_result;
  assign pop  = m_axis_tvalid & m_axis_tready;
  assign to_second = (out_cnt == 2'd2) || (out_cnt == 2'd1 && !pop);
  assign s_axis_tready = (out_cnt != 2'd2);
  assign m_axis_tvalid = (out_cnt != 2'd0);
  assign m_axis_tdata  = {(vmie_pkg::TDATA_W-1)'(0), obuf[0][0]};
  assign m_axis_tlast  = obuf[0][1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else begin
      out_cnt <= out_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // head entry takes the new result when it would be empty, else advances
  always_ff @(posedge clk) begin
    if (push && !to_second) begin
      obuf[0] <= {end_i & end_j & end_k, cube};
    end else if (pop) begin
      obuf[0] <= obuf[1];
    end
    if (push && to_second) begin
      obuf[1] <= {end_i & end_j & end_k, cube};
    end
  end

endmodule

>>> rtl/vmie_checker.sv
// Port-level checker for the erosion block, attached to the top level by bind.
// Depends on vmie_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vmie_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [vmie_pkg::TDATA_W-1:0]    s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vmie_pkg::TDATA_W-1:0]    m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [vmie_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [vmie_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic in_xfer, size_write;
  assign in_xfer    = s_axis_tvalid & s_axis_tready;
  assign size_write = cfg_valid & cfg_ready & (cfg_index <= vmie_pkg::REG_SIZE_THIRD);

  // a new result only appears after an input transfer
  `ASSERT_IMPLY(a_result_needs_input, clk, rst, $rose(m_axis_tvalid), $past(in_xfer))

  // input stalls only while results are waiting
  `ASSERT_IMPLY(a_stall_means_backlog, clk, rst, !s_axis_tready, m_axis_tvalid)

  // first voxel after a size write sits on the volume border: no result
  `ASSERT_NEXT(a_no_result_at_origin, clk, rst, (size_write && !in_xfer) ##1 in_xfer, !$rose(m_axis_tvalid))

  // a held result keeps its payload
  `ASSERT_NEXT(a_hold_result, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // only bit zero of the output data carries the result
  `ASSERT_IMPLY(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[vmie_pkg::TDATA_W-1:1] == '0)

endmodule

bind voxel_mask_inset_erosion vmie_checker u_vmie_checker (.*);
